@@ rtl/sstf_pkg.sv @@
// Package: sizes, codes and transaction types for the SSTF disk scheduler.
package sstf_pkg;

  // Store depth and used track width
  localparam int MAX_REQUESTS = 32;
  localparam int TRACK_BITS   = 16;

  // External field widths
  localparam int FIELD_W = 16;
  localparam int SUM_W   = 22;

  // Track bits that actually reach the datapath (input field is 16 bits)
  localparam int TRK_W = (TRACK_BITS < FIELD_W) ? TRACK_BITS : FIELD_W;
  // Cell index width and stored-count width
  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  // Request type codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] track;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] serviced_track;
    logic [FIELD_W-1:0] seek_distance;
    logic [SUM_W-1:0]   seek_total;
    logic               last;
  } out_item_t;

  // Best candidate handed from cell to cell during a scan
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [TRK_W-1:0] track;
    logic [TRK_W-1:0] gap;
  } cand_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic             clear;
    logic             mark;
    logic [IDX_W-1:0] mark_idx;
    logic [TRK_W-1:0] head;
    logic [TRK_W-1:0] load_track;
  } cell_ctl_t;

endpackage

@@ rtl/sstf_cell.sv @@
// One request cell: holds a track and its marks, and passes on the nearest candidate.
module sstf_cell
  import sstf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic             load_sel,
  input  logic [IDX_W-1:0] cell_idx,
  input  cand_t            cand_in,
  output cand_t            cand_out
);

  logic [TRK_W-1:0] track_r;
  logic             occ_r;
  logic             done_r;
  cand_t            cand_r;
  cand_t            cand_nxt;
  logic [TRK_W-1:0] gap;
  logic             take;

  // Distance from the head to this cell's request
  assign gap = (ctl.head >= track_r) ? (ctl.head - track_r) : (track_r - ctl.head);

  // Strictly nearer wins, so an earlier cell keeps a tie
  assign take = occ_r && !done_r && (!cand_in.found || (gap < cand_in.gap));

  always_comb begin
    cand_nxt = cand_in;
    if (take) begin
      cand_nxt.found = 1'b1;
      cand_nxt.idx   = cell_idx;
      cand_nxt.track = track_r;
      cand_nxt.gap   = gap;
    end
  end

  // Occupancy, serviced mark and candidate stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      done_r <= 1'b0;
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
      if (ctl.clear) begin
        occ_r  <= 1'b0;
        done_r <= 1'b0;
      end else begin
        if (load_sel) begin
          occ_r <= 1'b1;
        end
        if (ctl.mark && (ctl.mark_idx == cell_idx)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Stored track
  always_ff @(posedge clk) begin
    if (load_sel) begin
      track_r <= ctl.load_track;
    end
  end

  assign cand_out = cand_r;

endmodule

@@ rtl/sstf_disk_scheduler_unit.sv @@
// Top level: SSTF disk scheduler with a chain of request cells and a pick sequencer.
//
// A load transaction (req_type 0) stores one track request in the next free cell; loads
// beyond MAX_REQUESTS are dropped and produce no result. A run transaction
// (req_type 1) sets the head track and then services every stored request, nearest first,
// ties to the earliest loaded, giving one result per request with the last one flagged.
// Each pick lets the candidate walk the whole cell chain and waits out any output stall;
// the input is stalled until the run ends. A run with an empty store gives nothing and
// only moves the head. The store is empty again after a run.
module sstf_disk_scheduler_unit
  import sstf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] picks_r;
  logic [IDX_W-1:0] scan_r;
  logic [TRK_W-1:0] head_r;
  logic [SUM_W-1:0] sum_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  cand_t            chain [0:MAX_REQUESTS];
  cand_t            tail;
  cell_ctl_t        ctl;
  logic [MAX_REQUESTS-1:0] load_sel;
  logic             in_acc;
  logic             load_go;
  logic             out_free;
  logic             pick_go;
  logic             is_last;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_sat;
  logic [TRK_W-1:0] in_trk;

  // Handshake
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_trk   = in_data.track[TRK_W-1:0];
  assign load_go  = in_acc && (in_data.req_type == REQ_LOAD);
  assign out_free = !out_valid_r || !out_stall;

  // Pick control
  assign tail    = chain[MAX_REQUESTS];
  assign pick_go = (state_r == ST_PICK) && out_free;
  assign is_last = ((picks_r + CNT_W'(1)) == count_r);

  // Running seek total, saturating
  assign sum_ext = {1'b0, sum_r} + (SUM_W+1)'(tail.gap);
  assign sum_sat = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  // Broadcast to cells
  always_comb begin
    ctl.clear      = pick_go && is_last;
    ctl.mark       = pick_go;
    ctl.mark_idx   = tail.idx;
    ctl.head       = head_r;
    ctl.load_track = in_trk;
  end

  // Cell chain
  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    assign load_sel[i] = load_go && (count_r == CNT_W'(i));

    sstf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .load_sel (load_sel[i]),
      .cell_idx (IDX_W'(i)),
      .cand_in  (chain[i]),
      .cand_out (chain[i+1])
    );
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      picks_r     <= '0;
      scan_r      <= '0;
      head_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      // a new pick refills the register in the same cycle
      if (out_valid_r && !out_stall && !pick_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_data.req_type == REQ_LOAD) begin
              if (count_r != CNT_W'(MAX_REQUESTS)) begin
                count_r <= count_r + CNT_W'(1);
              end
            end else begin
              head_r  <= in_trk;
              sum_r   <= '0;
              picks_r <= '0;
              scan_r  <= '0;
              if (count_r != '0) begin
                state_r <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          // wait for the candidate to reach the end of the chain
          scan_r <= scan_r + IDX_W'(1);
          if (scan_r == IDX_W'(MAX_REQUESTS - 1)) begin
            state_r <= ST_PICK;
          end
        end
        ST_PICK: begin
          if (out_free) begin
            out_valid_r                <= 1'b1;
            out_data_r.serviced_track  <= FIELD_W'(tail.track);
            out_data_r.seek_distance   <= FIELD_W'(tail.gap);
            out_data_r.seek_total      <= sum_sat;
            out_data_r.last            <= is_last;
            head_r                     <= tail.track;
            sum_r                      <= sum_sat;
            picks_r                    <= picks_r + CNT_W'(1);
            scan_r                     <= '0;
            if (is_last) begin
              count_r <= '0;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/sstf_checker.sv @@
// Port-level checker for the SSTF disk scheduler, with its bind.
module sstf_checker
  import sstf_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // While a run is still in progress, no new transaction is taken
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input accepted in the middle of a run");

  // Running total never falls below the step distance
  a_total_ge_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.seek_total >= SUM_W'(out_data.seek_distance)))
    else $error("total seek below step distance");

endmodule

bind sstf_disk_scheduler_unit sstf_checker u_sstf_checker (.*);

@@ tb/sv/sstf_disk_scheduler_checker.sv @@
// Checker for the SSTF scheduler: watches both channels, predicts each run's picks and compares.
module sstf_disk_scheduler_checker
  import sstf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  // Saturation point of the running seek sum
  localparam logic [SUM_W:0] SEEK_SUM_MAX = {1'b0, {SUM_W{1'b1}}};
  // Keep the log short if the block is badly broken
  localparam int PRINT_CAP = 40;

  // Predicted copy of the block's state
  logic [TRK_W-1:0] req_track [MAX_REQUESTS];
  logic             req_done  [MAX_REQUESTS];
  int               req_count;
  logic [TRK_W-1:0] head_pos;

  // Picks predicted but not yet seen on the output
  out_item_t        pending_picks [$];
  out_item_t        want_pick;
  int               mismatches;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("[%0t] MISMATCH %s", $time, what);
    end
  endtask

  // Shortest seek first over the stored requests; ties go to the earliest load
  task automatic service_run(input logic [TRK_W-1:0] start);
    logic [TRK_W-1:0] gap;
    logic [TRK_W-1:0] best_gap;
    logic [SUM_W:0]   seek_sum;
    int               best;
    out_item_t        pick;
    head_pos = start;
    seek_sum = '0;
    for (int k = 0; k < req_count; k++) begin
      best     = -1;
      best_gap = '0;
      for (int i = 0; i < req_count; i++) begin
        if (!req_done[i]) begin
          gap = (head_pos >= req_track[i]) ? head_pos - req_track[i] : req_track[i] - head_pos;
          if (best < 0 || gap < best_gap) begin
            best     = i;
            best_gap = gap;
          end
        end
      end
      seek_sum = seek_sum + (SUM_W+1)'(best_gap);
      if (seek_sum > SEEK_SUM_MAX) seek_sum = SEEK_SUM_MAX;
      head_pos       = req_track[best];
      req_done[best] = 1'b1;
      pick.serviced_track = head_pos;
      pick.seek_distance  = best_gap;
      pick.seek_total     = seek_sum[SUM_W-1:0];
      pick.last           = (k == req_count - 1);
      pending_picks.insert(pending_picks.size(), pick);
    end
    // store empties after every run
    req_count = 0;
    for (int i = 0; i < MAX_REQUESTS; i++) req_done[i] = 1'b0;
  endtask

  // Sample both channels at the edge where transactions complete
  always @(posedge clk) begin
    if (!rst_n) begin
      req_count = 0;
      head_pos  = '0;
      pending_picks.delete();
      for (int i = 0; i < MAX_REQUESTS; i++) req_done[i] = 1'b0;
    end else begin
      // result transaction against the oldest prediction
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_picks.size() == 0) begin
          flag_mismatch($sformatf("unexpected result track=%0d dist=%0d total=%0d last=%0b",
                                  out_data.serviced_track, out_data.seek_distance,
                                  out_data.seek_total, out_data.last));
        end else begin
          want_pick = pending_picks.pop_front();
          if (out_data.serviced_track !== want_pick.serviced_track)
            flag_mismatch($sformatf("serviced_track got %0d want %0d",
                                    out_data.serviced_track, want_pick.serviced_track));
          if (out_data.seek_distance !== want_pick.seek_distance)
            flag_mismatch($sformatf("seek_distance got %0d want %0d",
                                    out_data.seek_distance, want_pick.seek_distance));
          if (out_data.seek_total !== want_pick.seek_total)
            flag_mismatch($sformatf("seek_total got %0d want %0d",
                                    out_data.seek_total, want_pick.seek_total));
          if (out_data.last !== want_pick.last)
            flag_mismatch($sformatf("last got %0b want %0b", out_data.last, want_pick.last));
        end
      end
      // input transaction: load appends unless full, run schedules
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        if (in_data.req_type == REQ_LOAD) begin
          if (req_count < MAX_REQUESTS) begin
            req_track[req_count] = in_data.track[TRK_W-1:0];
            req_count++;
          end
        end else begin
          service_run(in_data.track[TRK_W-1:0]);
        end
      end
    end
    fail_count <= mismatches;
    pending    <= pending_picks.size();
  end

endmodule

@@ tb/sv/sstf_disk_scheduler_unit_tb.sv @@
// Testbench top for the SSTF scheduler: clock, reset, stimulus, output stalls and verdict.
module sstf_disk_scheduler_unit_tb;
  import sstf_pkg::*;

  localparam int RANDOM_ITEMS  = 370;
  // one pick walks the whole cell chain
  localparam int PICK_CYCLES   = MAX_REQUESTS + 1;
  // quiet time after the last result: covers a run on an empty store
  localparam int SETTLE_CYCLES = 2 * PICK_CYCLES + 8;
  localparam int HOLD_CYCLES   = 600;
  // limit covers the slowest runs plus the idle gaps and the long hold
  localparam int CYCLE_LIMIT   = 400000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int cycles     = 0;

  // receiver state
  logic hold_go    = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;
  int   rx_mode    = 0;
  int   rx_span    = 0;

  // sender state
  int burst_left = 0;
  int loaded     = 0;
  int items_sent = 0;

  always #4 clk = ~clk;

  sstf_disk_scheduler_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sstf_disk_scheduler_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Offer one transaction; bursts of random length with idle gaps between them
  task automatic send_item(input logic kind, input logic [FIELD_W-1:0] trk);
    in_item_t item;
    item.req_type = kind;
    item.track    = trk;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    burst_left--;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    // dropped loads into a full store do not count
    if (kind == REQ_RUN) begin
      loaded = 0;
      items_sent++;
    end else if (loaded < MAX_REQUESTS) begin
      loaded++;
      items_sent++;
    end
  endtask

  // Stop offering until every predicted result is out, then let the block settle
  task automatic wait_drained();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Track mix: extremes, a cluster around base for ties and near picks, full range
  function automatic logic [FIELD_W-1:0] rand_track(input logic [FIELD_W-1:0] base);
    logic [FIELD_W-1:0] offs;
    logic [FIELD_W-1:0] full;
    offs = FIELD_W'($urandom_range(0, 8));
    full = FIELD_W'($urandom);
    case ($urandom_range(0, 9))
      0:       rand_track = '0;
      1:       rand_track = '1;
      2, 3, 4: rand_track = base + offs - 16'd4;
      default: rand_track = full;
    endcase
  endfunction

  // Receiver: stall modes that change over random spans, plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      if (rx_span == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_span <= $urandom_range(8, 150);
      end else begin
        rx_span <= rx_span - 1;
      end
      case (rx_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sstf_disk_scheduler_unit verification failed");
      $finish;
    end
  end

  // Stimulus and verdict
  initial begin
    int                 n;
    int                 sel;
    logic [FIELD_W-1:0] base;
    logic [FIELD_W-1:0] noise_trk;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // run with nothing stored
    send_item(REQ_RUN, 16'h0000);
    // both track extremes around a mid head
    send_item(REQ_LOAD, 16'hFFFF);
    send_item(REQ_LOAD, 16'h0000);
    send_item(REQ_RUN, 16'h8000);
    // equal gaps: the earlier load wins even though it is the higher track
    send_item(REQ_LOAD, 16'd20);
    send_item(REQ_LOAD, 16'd10);
    send_item(REQ_RUN, 16'd15);
    // duplicate tracks at the head, zero seeks
    send_item(REQ_LOAD, 16'd5);
    send_item(REQ_LOAD, 16'd5);
    send_item(REQ_RUN, 16'd5);
    // head at the top end, alternating bit patterns
    send_item(REQ_LOAD, 16'hAAAA);
    send_item(REQ_LOAD, 16'h5555);
    send_item(REQ_LOAD, 16'h0001);
    send_item(REQ_RUN, 16'hFFFF);
    wait_drained();
    // store must be empty after a run
    send_item(REQ_RUN, 16'h1234);
    // largest single seek
    send_item(REQ_LOAD, 16'hFFFF);
    send_item(REQ_RUN, 16'h0000);
    wait_drained();

    items_sent = 0;
    // full store plus dropped loads, then a run with the output held off
    // while more loads keep coming, so the block backs up into the input
    base = FIELD_W'($urandom);
    for (int j = 0; j < MAX_REQUESTS + 2; j++) send_item(REQ_LOAD, rand_track(base));
    hold_go <= 1'b1;
    send_item(REQ_RUN, rand_track(base));
    for (int j = 0; j < 6; j++) send_item(REQ_LOAD, rand_track(base));

    // mostly load sequences ending in a run, some single stray transactions
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 85) begin
        sel = $urandom_range(0, 9);
        if (sel < 6)      n = $urandom_range(1, 6);
        else if (sel < 9) n = $urandom_range(7, MAX_REQUESTS - 1);
        else              n = $urandom_range(MAX_REQUESTS, MAX_REQUESTS + 3);
        base = FIELD_W'($urandom);
        for (int j = 0; j < n; j++) send_item(REQ_LOAD, rand_track(base));
        send_item(REQ_RUN, rand_track(base));
      end else begin
        noise_trk = FIELD_W'($urandom);
        send_item(1'($urandom_range(0, 1)), noise_trk);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("sstf_disk_scheduler_unit verification clean");
    end else begin
      $display("sstf_disk_scheduler_unit verification failed");
    end
    $finish;
  end

endmodule
